### hdl/ahc_pkg.sv
`default_nettype none

package ahc_pkg;

  // Container header layout
  localparam int unsigned NONCE_BYTES  = 12;
  localparam int unsigned TAG_BYTES    = 16;
  localparam int unsigned MAGIC_LEN    = 4;
  localparam int unsigned LENGTH_BYTES = 8;
  localparam int unsigned VERSION_POS  = MAGIC_LEN;
  localparam int unsigned NONCE_POS    = VERSION_POS + 1;
  localparam int unsigned TAG_POS      = NONCE_POS + NONCE_BYTES;
  localparam int unsigned LEN_POS      = TAG_POS + TAG_BYTES;
  localparam int unsigned HEADER_LEN   = LEN_POS + LENGTH_BYTES;

  // Header position counter, holds up to the header size
  localparam int unsigned POS_W = 6;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t VERSION_P = pos_t'(VERSION_POS);
  localparam pos_t NONCE_P   = pos_t'(NONCE_POS);
  localparam pos_t TAG_P     = pos_t'(TAG_POS);
  localparam pos_t LEN_P     = pos_t'(LEN_POS);
  localparam pos_t HEADER_P  = pos_t'(HEADER_LEN);

  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  index_t;
  typedef logic [63:0] length_t;

  // Field kinds
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_MAGIC   = 3'd0;
  localparam kind_t KIND_VERSION = 3'd1;
  localparam kind_t KIND_NONCE   = 3'd2;
  localparam kind_t KIND_TAG     = 3'd3;
  localparam kind_t KIND_LENGTH  = 3'd4;
  localparam kind_t KIND_CIPHER  = 3'd5;

  // Verdict codes
  typedef logic [2:0] verdict_t;
  localparam verdict_t VERDICT_OK        = 3'd0;
  localparam verdict_t VERDICT_TRUNCATED = 3'd1;
  localparam verdict_t VERDICT_BAD_MAGIC = 3'd2;
  localparam verdict_t VERDICT_BAD_VER   = 3'd3;
  localparam verdict_t VERDICT_LEN_MISM  = 3'd4;

  localparam byte_t VERSION_RESET = 8'd1;

  // Magic bytes 'A','E','S','G'
  function automatic byte_t magic_byte(input logic [1:0] sel);
    byte_t b;
    unique case (sel)
      2'd0:    b = 8'h41;
      2'd1:    b = 8'h45;
      2'd2:    b = 8'h53;
      default: b = 8'h47;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/ahc_if.sv
`default_nettype none

// Byte stream request channel
interface ahc_in_if;
  logic          valid;
  logic          ready;
  ahc_pkg::byte_t data_byte;
  logic          end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// Tagged byte result channel
interface ahc_out_if;
  logic              valid;
  logic              ready;
  ahc_pkg::kind_t    field_kind;
  ahc_pkg::index_t   field_index;
  ahc_pkg::byte_t    byte_out;
  logic              final_flag;
  ahc_pkg::verdict_t verdict;
  ahc_pkg::length_t  declared_length;

  modport source (output valid, output field_kind, output field_index, output byte_out,
                  output final_flag, output verdict, output declared_length, input ready);
  modport sink   (input valid, input field_kind, input field_index, input byte_out,
                  input final_flag, input verdict, input declared_length, output ready);
endinterface

`default_nettype wire

### hdl/aead_container_header_checker.sv
// An accepted request is held in the input register and then loaded into the
// result register, from which its result is taken.
// Throughput: one request per cycle; the input stalls only when both registers
// hold a request and the result is not taken. Reset (rst, synchronous) clears
// both stages, the header position, error flags and counters, and sets
// expected_version to 1.
`default_nettype none

module aead_container_header_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_wr_en,
  input  wire ahc_pkg::byte_t cfg_wr_data,
  ahc_in_if.sink              stream,
  ahc_out_if.source           result
);
  import ahc_pkg::*;

  // Registers
  byte_t    expected_version;
  logic     s1_valid;
  byte_t    s1_byte;
  logic     s1_end;
  pos_t     header_position;
  logic     magic_error;
  logic     version_error;
  length_t  length_accumulator;
  length_t  payload_count;
  logic     out_valid;
  kind_t    out_kind;
  index_t   out_index;
  byte_t    out_byte;
  logic     out_final;
  verdict_t out_verdict;
  length_t  out_declared;

  // Next values
  pos_t     header_position_next;
  logic     magic_error_next;
  logic     version_error_next;
  length_t  length_accumulator_next;
  length_t  payload_count_next;
  kind_t    kind;
  index_t   index;
  verdict_t verdict;
  length_t  declared;
  logic [2:0] lane;

  // Handshake
  logic out_free;
  logic advance;
  logic accept;

  assign out_free     = !out_valid || result.ready;
  assign advance      = s1_valid && out_free;
  assign stream.ready = !s1_valid || out_free;
  assign accept       = stream.valid && stream.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
    end else if (cfg_wr_en) begin
      expected_version <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= stream.data_byte;
      s1_end  <= stream.end_of_data;
    end
  end

  // Field decode and state update for the byte in the input register
  always_comb begin
    header_position_next    = header_position;
    magic_error_next        = magic_error;
    version_error_next      = version_error;
    length_accumulator_next = length_accumulator;
    payload_count_next      = payload_count;
    kind                    = KIND_CIPHER;
    index                   = '0;
    lane                    = 3'(header_position - LEN_P);

    priority if (header_position < VERSION_P) begin
      kind  = KIND_MAGIC;
      index = {2'b00, header_position[1:0]};
      if (s1_byte != magic_byte(header_position[1:0])) begin
        magic_error_next = 1'b1;
      end
    end else if (header_position < NONCE_P) begin
      kind = KIND_VERSION;
      if (s1_byte != expected_version) begin
        version_error_next = 1'b1;
      end
    end else if (header_position < TAG_P) begin
      kind  = KIND_NONCE;
      index = 4'(header_position - NONCE_P);
    end else if (header_position < LEN_P) begin
      kind  = KIND_TAG;
      index = 4'(header_position - TAG_P);
    end else if (header_position < HEADER_P) begin
      // little-endian length, one byte lane per position
      kind  = KIND_LENGTH;
      index = {1'b0, lane};
      length_accumulator_next[{lane, 3'b000} +: 8] = s1_byte;
    end else begin
      // ciphertext index saturates at 15
      kind               = KIND_CIPHER;
      index              = (|payload_count[63:4]) ? 4'hF : payload_count[3:0];
      payload_count_next = payload_count + 64'd1;
    end

    if (header_position < HEADER_P) begin
      header_position_next = header_position + pos_t'(1);
    end
  end

  // Verdict on the closing byte
  always_comb begin
    verdict  = VERDICT_OK;
    declared = '0;
    if (s1_end) begin
      declared = length_accumulator_next;
      priority if (header_position_next < HEADER_P) begin
        verdict = VERDICT_TRUNCATED;
      end else if (magic_error_next) begin
        verdict = VERDICT_BAD_MAGIC;
      end else if (version_error_next) begin
        verdict = VERDICT_BAD_VER;
      end else if (payload_count_next != length_accumulator_next) begin
        verdict = VERDICT_LEN_MISM;
      end else begin
        verdict = VERDICT_OK;
      end
    end
  end

  // Container state; cleared after the closing byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position    <= '0;
      magic_error        <= 1'b0;
      version_error      <= 1'b0;
      length_accumulator <= '0;
      payload_count      <= '0;
    end else if (advance) begin
      if (s1_end) begin
        header_position    <= '0;
        magic_error        <= 1'b0;
        version_error      <= 1'b0;
        length_accumulator <= '0;
        payload_count      <= '0;
      end else begin
        header_position    <= header_position_next;
        magic_error        <= magic_error_next;
        version_error      <= version_error_next;
        length_accumulator <= length_accumulator_next;
        payload_count      <= payload_count_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind     <= kind;
      out_index    <= index;
      out_byte     <= s1_byte;
      out_final    <= s1_end;
      out_verdict  <= verdict;
      out_declared <= declared;
    end
  end

  assign result.valid           = out_valid;
  assign result.field_kind      = out_kind;
  assign result.field_index     = out_index;
  assign result.byte_out        = out_byte;
  assign result.final_flag      = out_final;
  assign result.verdict         = out_verdict;
  assign result.declared_length = out_declared;

  // Checks
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    header_position <= HEADER_P)
    else $error("header position beyond header size");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_end) |=> (header_position == '0 && !magic_error && !version_error
                             && payload_count == '0 && length_accumulator == '0))
    else $error("state not cleared after closing byte");

  a_count_only_after_header: assert property (@(posedge clk) disable iff (rst)
    (payload_count != '0) |-> (header_position == HEADER_P))
    else $error("ciphertext counted before header complete");

  a_verdict_only_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_final) |-> (out_verdict == VERDICT_OK && out_declared == '0))
    else $error("verdict on a non-final result");

  a_no_input_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !result.ready) |-> !stream.ready)
    else $error("request taken while both stages are held");

endmodule

`default_nettype wire

### dv/aead_container_header_checker_tb.sv
`default_nettype none

module aead_container_header_checker_tb;
  import ahc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned PHASE_BYTES     = 195;

  // One tagged byte as seen on the result channel
  typedef struct packed {
    kind_t    kind;
    index_t   idx;
    byte_t    data;
    logic     fin;
    verdict_t verdict;
    length_t  declared;
  } field_result_t;

  // Shapes of generated containers
  typedef enum int unsigned {
    CT_GOOD,
    CT_LEN_MISM,
    CT_BAD_MAGIC,
    CT_BAD_VER,
    CT_BAD_BOTH,
    CT_TRUNC,
    CT_NOISE
  } container_style_e;

  // Header tracker and store of expected tagged bytes
  class container_scoreboard;
    byte_t           version_want;
    int unsigned     hdr_seen;
    bit              magic_bad;
    bit              version_bad;
    length_t         len_build;
    length_t         cipher_count;
    field_result_t   expected_q[$];
    int unsigned     error_count;
    int unsigned     results_seen;
    int unsigned     verdict_hits[5];

    function new();
      version_want = VERSION_RESET;
      error_count  = 0;
      results_seen = 0;
      foreach (verdict_hits[i]) verdict_hits[i] = 0;
      clear_container();
    endfunction

    static function byte_t magic_char(int unsigned i);
      case (i)
        0:       return 8'h41;  // A
        1:       return 8'h45;  // E
        2:       return 8'h53;  // S
        default: return 8'h47;  // G
      endcase
    endfunction

    function void clear_container();
      hdr_seen     = 0;
      magic_bad    = 1'b0;
      version_bad  = 1'b0;
      len_build    = '0;
      cipher_count = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Work out the tagged byte for an accepted request
    function void note_request(byte_t b, logic eod);
      field_result_t r;
      int unsigned   pos;
      int unsigned   lane;
      r      = '0;
      r.data = b;
      r.fin  = eod;
      pos    = hdr_seen;
      if (pos < MAGIC_LEN) begin
        r.kind = KIND_MAGIC;
        r.idx  = index_t'(pos);
        if (b != magic_char(pos)) magic_bad = 1'b1;
      end else if (pos < NONCE_POS) begin
        r.kind = KIND_VERSION;
        r.idx  = '0;
        if (b != version_want) version_bad = 1'b1;
      end else if (pos < TAG_POS) begin
        r.kind = KIND_NONCE;
        r.idx  = index_t'(pos - NONCE_POS);
      end else if (pos < LEN_POS) begin
        r.kind = KIND_TAG;
        r.idx  = index_t'(pos - TAG_POS);
      end else if (pos < HEADER_LEN) begin
        // little-endian length, one lane per byte
        lane   = pos - LEN_POS;
        r.kind = KIND_LENGTH;
        r.idx  = index_t'(lane);
        len_build[8*lane +: 8] = b;
      end else begin
        r.kind = KIND_CIPHER;
        r.idx  = (cipher_count > 15) ? 4'd15 : index_t'(cipher_count);
        cipher_count = cipher_count + 1;
      end
      if (pos < HEADER_LEN) hdr_seen = pos + 1;

      // verdict in priority order, then back to a fresh container
      if (eod) begin
        r.declared = len_build;
        if (hdr_seen < HEADER_LEN)         r.verdict = VERDICT_TRUNCATED;
        else if (magic_bad)                r.verdict = VERDICT_BAD_MAGIC;
        else if (version_bad)              r.verdict = VERDICT_BAD_VER;
        else if (cipher_count != len_build) r.verdict = VERDICT_LEN_MISM;
        else                               r.verdict = VERDICT_OK;
        verdict_hits[r.verdict]++;
        clear_container();
      end
      expected_q = {expected_q, r};
    endfunction

    function void report(string what, field_result_t want, field_result_t got);
      error_count++;
      if (error_count <= 10) begin
        $display("[%0t] %s", $time, what);
        $display("  expected kind %0d idx %0d byte %02h final %0b verdict %0d length %016h",
                 want.kind, want.idx, want.data, want.fin, want.verdict, want.declared);
        $display("  actual   kind %0d idx %0d byte %02h final %0b verdict %0d length %016h",
                 got.kind, got.idx, got.data, got.fin, got.verdict, got.declared);
      end
    endfunction

    // Compare an accepted result with the oldest expectation
    function void check_result(field_result_t got);
      field_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind != want.kind || got.idx != want.idx || got.data != want.data ||
          got.fin != want.fin || got.verdict != want.verdict ||
          got.declared != want.declared)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  cfg_wr_en;
  byte_t cfg_wr_data;

  ahc_in_if  stream_if ();
  ahc_out_if result_if ();

  aead_container_header_checker u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stream      (stream_if),
    .result      (result_if)
  );

  container_scoreboard board = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_reqs;
  int unsigned hold_off_served;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  int unsigned containers_sent;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      board.check_result('{result_if.field_kind, result_if.field_index, result_if.byte_out,
                           result_if.final_flag, result_if.verdict,
                           result_if.declared_length});
    if (hold_off_reqs != hold_off_served) begin
      hold_off_served = hold_off_reqs;
      stall_left      = HOLD_OFF_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no progress for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one byte, idling at random first; valid stays high afterwards
  task automatic send_byte(input byte_t b, input logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid       <= 1'b1;
    stream_if.data_byte   <= b;
    stream_if.end_of_data <= eod;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    board.note_request(b, eod);
    bytes_sent++;
  endtask

  task automatic send_container(input byte_t bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    containers_sent++;
  endtask

  // Sender pauses until every tagged byte is back
  task automatic settle();
    stream_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_version(input byte_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.version_want = v;
  endtask

  function automatic container_style_e pick_style();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return CT_GOOD;
    if (roll < 45) return CT_LEN_MISM;
    if (roll < 55) return CT_BAD_MAGIC;
    if (roll < 65) return CT_BAD_VER;
    if (roll < 70) return CT_BAD_BOTH;
    if (roll < 90) return CT_TRUNC;
    return CT_NOISE;
  endfunction

  // Build one container: header, declared length, ciphertext, then damage; or random noise
  function automatic void build_container(input container_style_e style, input byte_t ver,
                                          output byte_t bytes[$]);
    int unsigned plen;
    int unsigned cut;
    length_t     decl;
    bytes.delete();
    if (style == CT_NOISE) begin
      repeat ($urandom_range(60, 1)) bytes = {bytes, byte_t'($urandom())};
      return;
    end
    for (int i = 0; i < MAGIC_LEN; i++) bytes = {bytes, container_scoreboard::magic_char(i)};
    bytes = {bytes, ver};
    repeat (NONCE_BYTES + TAG_BYTES) bytes = {bytes, byte_t'($urandom())};
    // mostly short payloads, some past the index saturation point
    plen = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16);
    decl = length_t'(plen);
    if (style == CT_LEN_MISM) begin
      case ($urandom_range(2))
        0:       decl = decl + 1;
        1:       decl = {$urandom(), $urandom()};
        default: plen = plen + 1;
      endcase
    end
    for (int i = 0; i < LENGTH_BYTES; i++) bytes = {bytes, decl[8*i +: 8]};
    repeat (plen) bytes = {bytes, byte_t'($urandom())};
    if (style == CT_BAD_MAGIC || style == CT_BAD_BOTH ||
        (style == CT_TRUNC && $urandom_range(1) == 1)) begin
      cut = $urandom_range(MAGIC_LEN - 1);
      bytes[cut] = bytes[cut] ^ (8'h01 << $urandom_range(7));
    end
    if (style == CT_BAD_VER || style == CT_BAD_BOTH)
      bytes[VERSION_POS] = bytes[VERSION_POS] ^ (8'h01 << $urandom_range(7));
    if (style == CT_TRUNC) begin
      cut = $urandom_range(HEADER_LEN - 1, 1);
      while (bytes.size() > cut) void'(bytes.pop_back());
    end
  endfunction

  initial begin : stimulus
    byte_t            cont[$];
    byte_t            phase_version;
    container_style_e style;
    int unsigned      phase_start;
    int unsigned      n_in_phase;

    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    stream_if.valid       = 1'b0;
    stream_if.data_byte   = '0;
    stream_if.end_of_data = 1'b0;
    result_if.ready       = 1'b0;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    hold_off_reqs         = 0;
    hold_off_served       = 0;
    stall_left            = 0;
    quiet_cycles          = 0;
    bytes_sent            = 0;
    containers_sent       = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one-byte containers at both extremes, truncations in the magic, version and nonce fields
    send_container('{8'h00});
    send_container('{8'hFF});
    send_container('{8'h41, 8'h45, 8'h53, 8'h47, VERSION_RESET});
    send_container('{8'h41, 8'h45, 8'h53, 8'h47, VERSION_RESET, 8'h00});
    send_container('{8'h41, 8'hBE});
    send_container('{8'h41, 8'h45, 8'h53, 8'hC7});
    settle();

    // Random phases: version extremes and a random one, different idling
    for (int phase = 1; phase <= 3; phase++) begin
      case (phase)
        1: begin
          phase_version = 8'h00;
          send_idle_pct = 28;
          recv_idle_pct <= 81;
        end
        2: begin
          phase_version = 8'hFF;
          send_idle_pct = 81;
          recv_idle_pct <= 28;
        end
        default: begin
          phase_version = byte_t'($urandom());
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      write_version(phase_version);
      // long receiver hold-off while the sender keeps pushing
      hold_off_reqs <= hold_off_reqs + 1;
      phase_start = bytes_sent;
      n_in_phase  = 0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // first phase walks every container shape once before going random
        if (phase == 1 && n_in_phase <= CT_NOISE) style = container_style_e'(n_in_phase);
        else style = pick_style();
        build_container(style, phase_version, cont);
        send_container(cont);
        n_in_phase++;
      end
      settle();
    end

    repeat (5) @(posedge clk);
    $display("covered %0d bytes in %0d containers, %0d tagged bytes checked",
             bytes_sent, containers_sent, board.results_seen);
    $display("verdicts: ok %0d, truncated %0d, bad magic %0d, bad version %0d, length %0d",
             board.verdict_hits[VERDICT_OK], board.verdict_hits[VERDICT_TRUNCATED],
             board.verdict_hits[VERDICT_BAD_MAGIC], board.verdict_hits[VERDICT_BAD_VER],
             board.verdict_hits[VERDICT_LEN_MISM]);
    if (board.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors", board.error_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
